// ===== sv/gpi_pkg.sv =====
package gpi_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_ENTRIES       = 4096;
   localparam int COEF_W            = 32;
   localparam int OUT_W             = 48;
   localparam int TAB_W             = 31;
   localparam int SH_ERF            = 31;
   localparam int SH_PDF            = 30;

   localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic        ov;
      logic [63:0] val;
   } res_type;

   // magnitude partial products of one signed 64x64 multiply
   typedef struct packed {
      logic        neg;
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } part_type;

   // per entry: erf in the upper half, density in the lower half, both Q30
   typedef logic [MAX_ENTRIES:0][2*TAB_W-1:0] tab_type;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic res_type sat_add(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      res_type     r;
      s = {x[63], x} + {y[63], y};
      r.ov = s[64] != s[63];
      r.val = r.ov ? (s[64] ? VAL_MIN : VAL_MAX) : s[63:0];
      return r;
   endfunction

   function automatic res_type sat_sub(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      res_type     r;
      s = {x[63], x} - {y[63], y};
      r.ov = s[64] != s[63];
      r.val = r.ov ? (s[64] ? VAL_MIN : VAL_MAX) : s[63:0];
      return r;
   endfunction

   // x times a small constant, saturating
   function automatic res_type sat_scale(input logic [63:0] x, input logic [2:0] k);
      logic signed [67:0] s;
      res_type            r;
      s = $signed({{4{x[63]}}, x}) * $signed({1'b0, k});
      r.ov = s[67:63] != {5{s[67]}};
      r.val = r.ov ? (s[67] ? VAL_MIN : VAL_MAX) : s[63:0];
      return r;
   endfunction

   function automatic part_type smul_part(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] ux;
      logic [63:0] uy;
      part_type    pt;
      ux = x[63] ? 64'd0 - x : x;
      uy = y[63] ? 64'd0 - y : y;
      pt.neg = x[63] ^ y[63];
      pt.p00 = {32'd0, ux[31:0]} * {32'd0, uy[31:0]};
      pt.p01 = {32'd0, ux[31:0]} * {32'd0, uy[63:32]};
      pt.p10 = {32'd0, ux[63:32]} * {32'd0, uy[31:0]};
      pt.p11 = {32'd0, ux[63:32]} * {32'd0, uy[63:32]};
      return pt;
   endfunction

   // sum partials, round half away from zero, shift right by sh, saturate
   function automatic res_type smul_fin(input part_type pt, input int sh);
      logic [127:0] full;
      logic [127:0] shf;
      res_type      r;
      full = {64'd0, pt.p00} + ({64'd0, pt.p01} << 32) + ({64'd0, pt.p10} << 32)
           + {pt.p11, 64'd0};
      full = full + (128'd1 << (sh - 1));
      shf = full >> sh;
      r.ov = (|shf[127:64]) || (shf[63:0] > (pt.neg ? VAL_MIN : VAL_MAX));
      if (r.ov) begin
         r.val = pt.neg ? VAL_MIN : VAL_MAX;
      end else begin
         r.val = pt.neg ? 64'd0 - shf[63:0] : shf[63:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rm;
      logic [63:0] q;
      rm = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rm = {rm[63:0], num[i]};
         if (rm >= {1'b0, den}) begin
            rm = rm - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                            input int bits);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = num;
      if (den == 64'd0) begin
         return 64'd0;
      end
      if (r >= den) begin
         q = 64'd1;
         r = r - den;
      end
      for (int i = 0; i < bits; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg_small(input logic [63:0] t);
      logic [63:0] sum;
      logic [63:0] term;
      sum = 64'd1 << 60;
      term = 64'd1 << 60;
      for (int n = 1; n <= 12; n++) begin
         term = mul_q60(term, t) / 64'(n);
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic tab_type build_tab(input int n);
      tab_type     tb;
      logic [63:0] ea [0:MAX_ENTRIES];
      logic [63:0] pa [0:MAX_ENTRIES];
      logic [63:0] p;
      logic [63:0] p2;
      logic [63:0] g;
      logic [63:0] r;
      logic [63:0] acc;
      logic [63:0] total;
      logic [63:0] k60;
      logic [63:0] g0;
      logic [63:0] g1;
      logic [63:0] g2;
      logic [63:0] nn;
      tb = '0;
      nn = 64'(n);
      p = exp_neg_small(udiv(64'h8000_0000_0000_0000, nn * nn));
      p2 = mul_q60(p, p);
      g = 64'd1 << 60;
      r = p;
      acc = '0;
      ea[0] = '0;
      pa[0] = g;
      for (int k = 0; k < n; k++) begin
         g0 = g;
         g = mul_q60(g, r);
         r = mul_q60(r, p2);
         g1 = g;
         g = mul_q60(g, r);
         r = mul_q60(r, p2);
         g2 = g;
         acc = acc + (g0 >> 10) + 64'd4 * (g1 >> 10) + (g2 >> 10);
         ea[k + 1] = acc;
         pa[k + 1] = g2;
      end
      total = acc;
      k60 = frac_div((64'd3 * nn) << 47, total, 60);
      for (int k = 0; k <= n; k++) begin
         tb[k] = {TAB_W'((frac_div(ea[k], total, 31) + 64'd1) >> 1),
                  TAB_W'((mul_q60(pa[k], k60) + (64'd1 << 29)) >> 30)};
      end
      return tb;
   endfunction

endpackage

// ===== sv/gpi_req_if.sv =====
interface gpi_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic signed [31:0] coef_quartic;
   logic signed [31:0] coef_cubic;
   logic signed [31:0] coef_square;
   logic signed [31:0] coef_linear;
   logic signed [31:0] coef_const;
   logic signed [31:0] shift;
   logic signed [31:0] lower_bound;
   logic signed [31:0] upper_bound;

   modport source (output valid, func, coef_quartic, coef_cubic, coef_square, coef_linear,
                   coef_const, shift, lower_bound, upper_bound, input ready);
   modport sink (input valid, func, coef_quartic, coef_cubic, coef_square, coef_linear,
                 coef_const, shift, lower_bound, upper_bound, output ready);
endinterface

// ===== sv/gpi_rsp_if.sv =====
interface gpi_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [47:0] integral;
   logic        saturated;

   modport source (output valid, integral, saturated, input ready);
   modport sink (input valid, integral, saturated, output ready);
endinterface

// ===== sv/gpi_lookup.sv =====
// erf(y/sqrt2) and phi(y) by table and linear interpolation, four register stages
module gpi_lookup #(
   parameter int FRAC_BITS     = gpi_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = gpi_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] y,
   output logic [31:0] erf_val,
   output logic [31:0] pdf_val
);

   localparam int RW = FRAC_BITS + 3;
   localparam int KW = $clog2(TABLE_ENTRIES + 1);
   localparam int PW = RW + 33;
   localparam int TW = gpi_pkg::TAB_W;
   localparam logic [33:0] LIM = 34'd8 << FRAC_BITS;
   localparam logic [KW-1:0] LAST_K = KW'(TABLE_ENTRIES);
   localparam logic [PW-1:0] RND = (PW'(1) << RW) - PW'(1);
   localparam gpi_pkg::tab_type TAB = gpi_pkg::build_tab(TABLE_ENTRIES);

   logic [31:0]      mag;
   logic [33:0]      mag34;
   logic [RW+KW-1:0] pos;
   logic             far_in, far1_ff;
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [KW-1:0]    k_in, k1_ff;
   logic [KW-1:0]    kk;
   logic [RW-1:0]    rem_in, rem1_ff, rem2_ff;
   logic [31:0]      e0_in, e0_2_ff, e0_3_ff;
   logic [31:0]      p0_in, p0_2_ff, p0_3_ff;
   logic [31:0]      de_in, de_ff;
   logic [31:0]      dp_in, dp_ff;
   logic signed [PW-1:0] pe_in, pe_ff;
   logic signed [PW-1:0] pp_in, pp_ff;
   logic [PW-1:0]    qe, qp;
   logic [31:0]      ev;
   logic [31:0]      e_in, e_ff;
   logic [31:0]      p_in, p_ff;

   always_comb begin
      mag = y[31] ? 32'd0 - y : y;
      mag34 = {2'b00, mag};
      far_in = mag34 >= LIM;
      pos = {{KW{1'b0}}, mag34[RW-1:0]} * (RW + KW)'(TABLE_ENTRIES);
      k_in = pos[RW+KW-1:RW];
      rem_in = pos[RW-1:0];

      kk = far1_ff ? LAST_K : k1_ff;
      e0_in = {1'b0, TAB[kk][2*TW-1:TW]};
      p0_in = {1'b0, TAB[kk][TW-1:0]};
      if (far1_ff) begin
         de_in = '0;
         dp_in = '0;
      end else begin
         de_in = {1'b0, TAB[k1_ff + KW'(1)][2*TW-1:TW]} - {1'b0, TAB[k1_ff][2*TW-1:TW]};
         dp_in = {1'b0, TAB[k1_ff + KW'(1)][TW-1:0]} - {1'b0, TAB[k1_ff][TW-1:0]};
      end

      pe_in = $signed(de_ff) * $signed({1'b0, rem2_ff});
      pp_in = $signed(dp_ff) * $signed({1'b0, rem2_ff});

      // interpolation step truncates toward zero
      qe = $unsigned(($signed(pe_ff) + $signed(pe_ff[PW-1] ? RND : '0)) >>> RW);
      qp = $unsigned(($signed(pp_ff) + $signed(pp_ff[PW-1] ? RND : '0)) >>> RW);
      ev = e0_3_ff + qe[31:0];
      e_in = neg3_ff ? 32'd0 - ev : ev;
      p_in = p0_3_ff + qp[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         far1_ff <= far_in;
         neg1_ff <= y[31];
         k1_ff <= k_in;
         rem1_ff <= rem_in;
         neg2_ff <= neg1_ff;
         e0_2_ff <= e0_in;
         p0_2_ff <= p0_in;
         de_ff <= de_in;
         dp_ff <= dp_in;
         rem2_ff <= rem1_ff;
         neg3_ff <= neg2_ff;
         e0_3_ff <= e0_2_ff;
         p0_3_ff <= p0_2_ff;
         pe_ff <= pe_in;
         pp_ff <= pp_in;
         e_ff <= e_in;
         p_ff <= p_in;
      end
   end

   assign erf_val = e_ff;
   assign pdf_val = p_ff;

endmodule

// ===== sv/gaussian_polynomial_integral_top.sv =====
// channel   dir  payload                                              handshake
// req_bus   in   func, coef_quartic..coef_const, shift, bounds        valid/ready
// rsp_bus   out  integral (Q31.16, clamped), saturated                valid/ready
//
// One beat in per cycle while the output is not held; results leave in request order.
// Depth is set by the chains of split 64x64 multiplies (shift expansion, y^3, phi*poly).
// Reset clears only the valid bits; the tables are constants.
// When the output beat is held and not taken, the whole pipeline freezes and
// req_bus.ready drops; nothing moves until rsp_bus.ready returns.
module gaussian_polynomial_integral_top #(
   parameter int FRAC_BITS     = gpi_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = gpi_pkg::TABLE_ENTRIES_DEF
) (
   input logic      clock,
   input logic      reset,
   gpi_req_if.sink  req_bus,
   gpi_rsp_if.source rsp_bus
);

   localparam int NS = 26;
   localparam int LAST = NS - 1;

   typedef struct packed {
      logic        func;
      logic        ov;
      logic        ovs;
      logic [1:0]  ovb;
      logic [63:0] a, b, c, d, e, h;
      logic [63:0] h2, h3, h4;
      logic [63:0] a4h, b3h, c2h, dh, a6h2, b3h2, ch2, a4h3, bh3, ah4;
      logic [63:0] nb, nc, nd, ne;
      logic [63:0] q2, q3, mass, r;
      logic [1:0][31:0] y;
      logic [1:0][31:0] ev;
      logic [1:0][31:0] pv;
      logic [1:0][63:0] y2, y3, q0y3, q1y2, q2y, qy, t1, t2, f;
      gpi_pkg::part_type [6:0] pp;
   } ctx_type;

   ctx_type        st_in [NS];
   ctx_type        st_ff [NS];
   logic [NS-1:0]  vld_in, vld_ff;
   logic           en;
   logic [1:0][31:0] lk_erf, lk_pdf;

   assign en = !vld_ff[LAST] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign vld_in = {vld_ff[NS-2:0], req_bus.valid};

   for (genvar j = 0; j < 2; j++) begin : g_lk
      gpi_lookup #(
         .FRAC_BITS     (FRAC_BITS),
         .TABLE_ENTRIES (TABLE_ENTRIES)
      ) u_lookup (
         .clock   (clock),
         .en      (en),
         .y       (st_ff[0].y[j]),
         .erf_val (lk_erf[j]),
         .pdf_val (lk_pdf[j])
      );
   end

   always_comb begin
      gpi_pkg::res_type rt;
      logic [63:0]      rv;
      logic [47:0]      r48;

      st_in[0] = '0;
      st_in[0].func = req_bus.func;
      st_in[0].a = gpi_pkg::sext32(req_bus.coef_quartic);
      st_in[0].b = gpi_pkg::sext32(req_bus.coef_cubic);
      st_in[0].c = gpi_pkg::sext32(req_bus.coef_square);
      st_in[0].d = gpi_pkg::sext32(req_bus.coef_linear);
      st_in[0].e = gpi_pkg::sext32(req_bus.coef_const);
      st_in[0].h = gpi_pkg::sext32(req_bus.shift);
      st_in[0].y[0] = req_bus.lower_bound;
      st_in[0].y[1] = req_bus.upper_bound;
      for (int i = 1; i < NS; i++) begin
         st_in[i] = st_ff[i-1];
      end

      // products with h, and y^2
      st_in[1].pp[0] = gpi_pkg::smul_part(st_ff[0].h, st_ff[0].h);
      st_in[1].pp[1] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[0].a, 3'd4).val,
                                          st_ff[0].h);
      st_in[1].pp[2] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[0].b, 3'd3).val,
                                          st_ff[0].h);
      st_in[1].pp[3] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[0].c, 3'd2).val,
                                          st_ff[0].h);
      st_in[1].pp[4] = gpi_pkg::smul_part(st_ff[0].d, st_ff[0].h);
      for (int j = 0; j < 2; j++) begin
         st_in[1].pp[5+j] = gpi_pkg::smul_part(gpi_pkg::sext32(st_ff[0].y[j]),
                                               gpi_pkg::sext32(st_ff[0].y[j]));
      end

      rt = gpi_pkg::smul_fin(st_ff[1].pp[0], FRAC_BITS);
      st_in[2].h2 = rt.val;
      st_in[2].ovs = st_in[2].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[1].pp[1], FRAC_BITS);
      st_in[2].a4h = rt.val;
      st_in[2].ovs = st_in[2].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[1].pp[2], FRAC_BITS);
      st_in[2].b3h = rt.val;
      st_in[2].ovs = st_in[2].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[1].pp[3], FRAC_BITS);
      st_in[2].c2h = rt.val;
      st_in[2].ovs = st_in[2].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[1].pp[4], FRAC_BITS);
      st_in[2].dh = rt.val;
      st_in[2].ovs = st_in[2].ovs | rt.ov;
      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::smul_fin(st_ff[1].pp[5+j], FRAC_BITS);
         st_in[2].y2[j] = rt.val;
         st_in[2].ovb[j] = st_in[2].ovb[j] | rt.ov;
      end

      st_in[3].pp[0] = gpi_pkg::smul_part(st_ff[2].h2, st_ff[2].h);
      st_in[3].pp[1] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[2].a, 3'd6).val,
                                          st_ff[2].h2);
      st_in[3].pp[2] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[2].b, 3'd3).val,
                                          st_ff[2].h2);
      st_in[3].pp[3] = gpi_pkg::smul_part(st_ff[2].c, st_ff[2].h2);
      for (int j = 0; j < 2; j++) begin
         st_in[3].pp[4+j] = gpi_pkg::smul_part(st_ff[2].y2[j],
                                               gpi_pkg::sext32(st_ff[2].y[j]));
      end
      rt = gpi_pkg::sat_sub(st_ff[2].b, st_ff[2].a4h);
      st_in[3].nb = rt.val;
      st_in[3].ovs = st_in[3].ovs | rt.ov;

      rt = gpi_pkg::smul_fin(st_ff[3].pp[0], FRAC_BITS);
      st_in[4].h3 = rt.val;
      st_in[4].ovs = st_in[4].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[3].pp[1], FRAC_BITS);
      st_in[4].a6h2 = rt.val;
      st_in[4].ovs = st_in[4].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[3].pp[2], FRAC_BITS);
      st_in[4].b3h2 = rt.val;
      st_in[4].ovs = st_in[4].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[3].pp[3], FRAC_BITS);
      st_in[4].ch2 = rt.val;
      st_in[4].ovs = st_in[4].ovs | rt.ov;
      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::smul_fin(st_ff[3].pp[4+j], FRAC_BITS);
         st_in[4].y3[j] = rt.val;
         st_in[4].ovb[j] = st_in[4].ovb[j] | rt.ov;
      end

      // table results line up with this stage
      st_in[5].ev = lk_erf;
      st_in[5].pv = lk_pdf;
      st_in[5].pp[0] = gpi_pkg::smul_part(st_ff[4].h3, st_ff[4].h);
      st_in[5].pp[1] = gpi_pkg::smul_part(gpi_pkg::sat_scale(st_ff[4].a, 3'd4).val,
                                          st_ff[4].h3);
      st_in[5].pp[2] = gpi_pkg::smul_part(st_ff[4].b, st_ff[4].h3);
      rt = gpi_pkg::sat_sub(st_ff[4].a6h2, st_ff[4].b3h);
      st_in[5].nc = rt.val;
      st_in[5].ovs = st_in[5].ovs | rt.ov;

      rt = gpi_pkg::smul_fin(st_ff[5].pp[0], FRAC_BITS);
      st_in[6].h4 = rt.val;
      st_in[6].ovs = st_in[6].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[5].pp[1], FRAC_BITS);
      st_in[6].a4h3 = rt.val;
      st_in[6].ovs = st_in[6].ovs | rt.ov;
      rt = gpi_pkg::smul_fin(st_ff[5].pp[2], FRAC_BITS);
      st_in[6].bh3 = rt.val;
      st_in[6].ovs = st_in[6].ovs | rt.ov;
      rt = gpi_pkg::sat_add(st_ff[5].nc, st_ff[5].c);
      st_in[6].nc = rt.val;
      st_in[6].ovs = st_in[6].ovs | rt.ov;

      st_in[7].pp[0] = gpi_pkg::smul_part(st_ff[6].a, st_ff[6].h4);
      rt = gpi_pkg::sat_sub(st_ff[6].b3h2, st_ff[6].a4h3);
      st_in[7].nd = rt.val;
      st_in[7].ovs = st_in[7].ovs | rt.ov;

      rt = gpi_pkg::smul_fin(st_ff[7].pp[0], FRAC_BITS);
      st_in[8].ah4 = rt.val;
      st_in[8].ovs = st_in[8].ovs | rt.ov;
      rt = gpi_pkg::sat_sub(st_ff[7].nd, st_ff[7].c2h);
      st_in[8].nd = rt.val;
      st_in[8].ovs = st_in[8].ovs | rt.ov;

      rt = gpi_pkg::sat_sub(st_ff[8].ah4, st_ff[8].bh3);
      st_in[9].ne = rt.val;
      st_in[9].ovs = st_in[9].ovs | rt.ov;
      rt = gpi_pkg::sat_add(st_ff[8].nd, st_ff[8].d);
      st_in[9].nd = rt.val;
      st_in[9].ovs = st_in[9].ovs | rt.ov;

      rt = gpi_pkg::sat_add(st_ff[9].ne, st_ff[9].ch2);
      st_in[10].ne = rt.val;
      st_in[10].ovs = st_in[10].ovs | rt.ov;

      rt = gpi_pkg::sat_sub(st_ff[10].ne, st_ff[10].dh);
      st_in[11].ne = rt.val;
      st_in[11].ovs = st_in[11].ovs | rt.ov;

      rt = gpi_pkg::sat_add(st_ff[11].ne, st_ff[11].e);
      st_in[12].ne = rt.val;
      st_in[12].ovs = st_in[12].ovs | rt.ov;

      // shifted mode takes the re-expanded coefficients and their overflow
      if (st_ff[12].func) begin
         st_in[13].b = st_ff[12].nb;
         st_in[13].c = st_ff[12].nc;
         st_in[13].d = st_ff[12].nd;
         st_in[13].e = st_ff[12].ne;
         st_in[13].ov = st_ff[12].ov | st_ff[12].ovs;
      end

      rt = gpi_pkg::sat_scale(st_ff[13].a, 3'd3);
      st_in[14].q2 = rt.val;
      st_in[14].ov = st_in[14].ov | rt.ov;
      rt = gpi_pkg::sat_scale(st_ff[13].b, 3'd2);
      st_in[14].q3 = rt.val;
      st_in[14].ov = st_in[14].ov | rt.ov;

      rt = gpi_pkg::sat_add(st_ff[14].q2, st_ff[14].c);
      st_in[15].q2 = rt.val;
      st_in[15].ov = st_in[15].ov | rt.ov;
      rt = gpi_pkg::sat_add(st_ff[14].q3, st_ff[14].d);
      st_in[15].q3 = rt.val;
      st_in[15].ov = st_in[15].ov | rt.ov;

      rt = gpi_pkg::sat_add(st_ff[15].q2, st_ff[15].e);
      st_in[16].mass = rt.val;
      st_in[16].ov = st_in[16].ov | rt.ov;
      for (int j = 0; j < 2; j++) begin
         st_in[16].pp[3*j]   = gpi_pkg::smul_part(st_ff[15].a, st_ff[15].y3[j]);
         st_in[16].pp[3*j+1] = gpi_pkg::smul_part(st_ff[15].b, st_ff[15].y2[j]);
         st_in[16].pp[3*j+2] = gpi_pkg::smul_part(st_ff[15].q2,
                                                  gpi_pkg::sext32(st_ff[15].y[j]));
      end

      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::smul_fin(st_ff[16].pp[3*j], FRAC_BITS);
         st_in[17].q0y3[j] = rt.val;
         st_in[17].ovb[j] = st_in[17].ovb[j] | rt.ov;
         rt = gpi_pkg::smul_fin(st_ff[16].pp[3*j+1], FRAC_BITS);
         st_in[17].q1y2[j] = rt.val;
         st_in[17].ovb[j] = st_in[17].ovb[j] | rt.ov;
         rt = gpi_pkg::smul_fin(st_ff[16].pp[3*j+2], FRAC_BITS);
         st_in[17].q2y[j] = rt.val;
         st_in[17].ovb[j] = st_in[17].ovb[j] | rt.ov;
      end
      for (int j = 0; j < 2; j++) begin
         st_in[17].pp[j] = gpi_pkg::smul_part(st_ff[16].mass,
                                              gpi_pkg::sext32(st_ff[16].ev[j]));
      end

      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::smul_fin(st_ff[17].pp[j], gpi_pkg::SH_ERF);
         st_in[18].t1[j] = rt.val;
         st_in[18].ov = st_in[18].ov | rt.ov;
         rt = gpi_pkg::sat_add(st_ff[17].q0y3[j], st_ff[17].q1y2[j]);
         st_in[18].qy[j] = rt.val;
         st_in[18].ovb[j] = st_in[18].ovb[j] | rt.ov;
      end

      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::sat_add(st_ff[18].qy[j], st_ff[18].q2y[j]);
         st_in[19].qy[j] = rt.val;
         st_in[19].ovb[j] = st_in[19].ovb[j] | rt.ov;
      end

      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::sat_add(st_ff[19].qy[j], st_ff[19].q3);
         st_in[20].qy[j] = rt.val;
         st_in[20].ovb[j] = st_in[20].ovb[j] | rt.ov;
      end

      for (int j = 0; j < 2; j++) begin
         st_in[21].pp[j] = gpi_pkg::smul_part(gpi_pkg::sext32(st_ff[20].pv[j]),
                                              st_ff[20].qy[j]);
      end

      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::smul_fin(st_ff[21].pp[j], gpi_pkg::SH_PDF);
         st_in[22].t2[j] = rt.val;
         st_in[22].ovb[j] = st_in[22].ovb[j] | rt.ov;
      end

      // a zero density drops the polynomial term and its overflow
      for (int j = 0; j < 2; j++) begin
         rt = gpi_pkg::sat_sub(st_ff[22].t1[j],
                               (st_ff[22].pv[j] != 32'd0) ? st_ff[22].t2[j] : 64'd0);
         st_in[23].f[j] = rt.val;
         st_in[23].ov = st_in[23].ov | rt.ov
                      | ((st_ff[22].pv[j] != 32'd0) && st_ff[22].ovb[j]);
      end

      rt = gpi_pkg::sat_sub(st_ff[23].f[1], st_ff[23].f[0]);
      st_in[24].r = rt.val;
      st_in[24].ov = st_in[24].ov | rt.ov;

      rv = st_ff[24].r;
      r48 = rv[47:0];
      if (rv[63:47] != {17{rv[63]}}) begin
         r48 = rv[63] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
         st_in[25].r = {{16{r48[47]}}, r48};
         st_in[25].ov = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign rsp_bus.valid = vld_ff[LAST];
   assign rsp_bus.integral = st_ff[LAST].r[gpi_pkg::OUT_W-1:0];
   assign rsp_bus.saturated = st_ff[LAST].ov;

endmodule

// ===== test/gpi_tb_if.sv =====
`timescale 1ns / 100ps
// Channel interfaces come from the RTL; this file carries the beat record the bench queues.
package gpi_tb_pkg;
   typedef struct {
      logic        func;
      logic [31:0] qa, qb, qc, qd, qe, hs, lo, hi;
   } gpi_item_type;
endpackage

// ===== test/tb_gaussian_polynomial_integral_top.sv =====
`timescale 1ns / 100ps
module tb_gaussian_polynomial_integral_top;

   localparam int NF = 16;
   localparam int NT = 256;
   localparam longint IMAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint IMIN = 64'sh8000_0000_0000_0000;
   localparam longint OMAX = 64'sd140737488355327;
   localparam longint OMIN = -64'sd140737488355328;
   localparam int WD_LIMIT = 5000;

   logic clock = 0;
   logic reset = 1;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   gpi_req_if req_bus ();
   gpi_rsp_if rsp_bus ();

   gaussian_polynomial_integral_top dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   // erf/phi tables in Q30
   longint erf_tab [0:NT];
   longint pdf_tab [0:NT];

   function automatic logic [63:0] q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] fdiv(logic [63:0] num, logic [63:0] den, int bits);
      logic [63:0] q, r;
      q = 0;
      r = num;
      if (den == 0) return 0;
      if (r >= den) begin
         q = 1;
         r = r - den;
      end
      for (int i = 0; i < bits; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1;
         end
      end
      return q;
   endfunction

   task automatic fill_tables();
      logic [63:0] p, p2, g, r, acc, k60, t, sum, term, g0, g1, g2;
      logic [63:0] ea [0:NT];
      logic [63:0] pa [0:NT];
      t = 64'h8000_0000_0000_0000 / (NT * NT);
      sum = 64'd1 << 60;
      term = sum;
      for (int n = 1; n <= 12; n++) begin
         term = q60(term, t) / n;
         if (n % 2) sum = sum - term;
         else sum = sum + term;
      end
      p = sum;
      p2 = q60(p, p);
      g = 64'd1 << 60;
      r = p;
      acc = 0;
      ea[0] = 0;
      pa[0] = g;
      for (int k = 0; k < NT; k++) begin
         g0 = g;
         g = q60(g, r); r = q60(r, p2); g1 = g;
         g = q60(g, r); r = q60(r, p2); g2 = g;
         acc = acc + (g0 >> 10) + 4 * (g1 >> 10) + (g2 >> 10);
         ea[k + 1] = acc;
         pa[k + 1] = g2;
      end
      k60 = fdiv((64'd3 * NT) << 47, acc, 60);
      for (int k = 0; k <= NT; k++) begin
         erf_tab[k] = (fdiv(ea[k], acc, 31) + 1) >> 1;
         pdf_tab[k] = (q60(pa[k], k60) + (64'd1 << 29)) >> 30;
      end
   endtask

   // rounded shifted product, saturating
   function automatic longint rmul(longint x, longint y, int sh, ref bit ov);
      logic [63:0] ux, uy, lim;
      logic [127:0] f;
      bit neg;
      neg = (x < 0) != (y < 0);
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      f = ({64'd0, ux} * {64'd0, uy} + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (|f[127:64] || f[63:0] > lim) begin
         ov = 1;
         return neg ? IMIN : IMAX;
      end
      return neg ? -longint'(f[63:0]) : longint'(f[63:0]);
   endfunction

   function automatic longint sadd(longint a, longint b, ref bit ov);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > IMAX) begin ov = 1; return IMAX; end
      if (s < IMIN) begin ov = 1; return IMIN; end
      return longint'(s);
   endfunction

   function automatic longint ssub(longint a, longint b, ref bit ov);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > IMAX) begin ov = 1; return IMAX; end
      if (s < IMIN) begin ov = 1; return IMIN; end
      return longint'(s);
   endfunction

   function automatic longint qm(longint x, longint y, ref bit ov);
      return rmul(x, y, NF, ov);
   endfunction

   function automatic longint kx(longint x, longint k, ref bit ov);
      return rmul(x, 2 * k, 1, ov);
   endfunction

   function automatic longint prim(longint y, longint mass, longint q [4], ref bit ov);
      longint m, lim, pos, k, rem, ev, pv, t1, t2, y2, y3, qy;
      m = y < 0 ? -y : y;
      lim = 64'sd8 << NF;
      if (m >= lim) begin
         ev = erf_tab[NT];
         pv = pdf_tab[NT];
      end else begin
         pos = m * NT;
         k = pos / lim;
         rem = pos % lim;
         ev = erf_tab[k] + (erf_tab[k + 1] - erf_tab[k]) * rem / lim;
         pv = pdf_tab[k] + (pdf_tab[k + 1] - pdf_tab[k]) * rem / lim;
      end
      if (y < 0) ev = -ev;
      t1 = rmul(mass, ev, 31, ov);
      t2 = 0;
      if (pv != 0) begin
         y2 = qm(y, y, ov);
         y3 = qm(y2, y, ov);
         qy = qm(q[0], y3, ov);
         qy = sadd(qy, qm(q[1], y2, ov), ov);
         qy = sadd(qy, qm(q[2], y, ov), ov);
         qy = sadd(qy, q[3], ov);
         t2 = rmul(pv, qy, 30, ov);
      end
      return ssub(t1, t2, ov);
   endfunction

   function automatic void integrate(gpi_tb_pkg::gpi_item_type it, output longint res,
                                     output bit sat);
      longint a, b, c, d, e, h, h2, h3, h4, nb, nc, nd, ne, mass, r;
      longint q [4];
      bit ov;
      ov = 0;
      a = longint'($signed(it.qa)); b = longint'($signed(it.qb));
      c = longint'($signed(it.qc)); d = longint'($signed(it.qd));
      e = longint'($signed(it.qe));
      if (it.func) begin
         h = longint'($signed(it.hs));
         h2 = qm(h, h, ov); h3 = qm(h2, h, ov); h4 = qm(h3, h, ov);
         nb = ssub(b, qm(kx(a, 4, ov), h, ov), ov);
         nc = ssub(qm(kx(a, 6, ov), h2, ov), qm(kx(b, 3, ov), h, ov), ov);
         nc = sadd(nc, c, ov);
         nd = ssub(qm(kx(b, 3, ov), h2, ov), qm(kx(a, 4, ov), h3, ov), ov);
         nd = ssub(nd, qm(kx(c, 2, ov), h, ov), ov);
         nd = sadd(nd, d, ov);
         ne = ssub(qm(a, h4, ov), qm(b, h3, ov), ov);
         ne = sadd(ne, qm(c, h2, ov), ov);
         ne = ssub(ne, qm(d, h, ov), ov);
         ne = sadd(ne, e, ov);
         b = nb; c = nc; d = nd; e = ne;
      end
      q[0] = a;
      q[1] = b;
      q[2] = sadd(kx(a, 3, ov), c, ov);
      q[3] = sadd(kx(b, 2, ov), d, ov);
      mass = sadd(q[2], e, ov);
      r = ssub(prim(longint'($signed(it.hi)), mass, q, ov),
               prim(longint'($signed(it.lo)), mass, q, ov), ov);
      if (r > OMAX) begin r = OMAX; ov = 1; end
      if (r < OMIN) begin r = OMIN; ov = 1; end
      res = r;
      sat = ov;
   endfunction

   class integral_board;
      longint want_val [$];
      bit     want_sat [$];
      int     errors = 0;

      function void note_request(gpi_tb_pkg::gpi_item_type it);
         longint r;
         bit s;
         integrate(it, r, s);
         want_val.push_back(r);
         want_sat.push_back(s);
      endfunction

      function void check_result(logic [47:0] val, logic sat);
         longint wv;
         bit ws;
         if (want_val.size() == 0) begin
            $error("unexpected result beat integral=%h", val);
            errors++;
            return;
         end
         wv = want_val.pop_front();
         ws = want_sat.pop_front();
         if (val !== wv[47:0]) begin
            $error("integral: expected %h actual %h", wv[47:0], val);
            errors++;
         end
         if (sat !== ws) begin
            $error("saturated: expected %0d actual %0d", ws, sat);
            errors++;
         end
      endfunction
   endclass

   integral_board board = new();
   gpi_tb_pkg::gpi_item_type stim [$];
   bit sending_done = 0;
   int hold_off = 0;
   int idle_cycles = 0;

   initial begin
      req_bus.valid = 0;
      req_bus.func = 0;
      req_bus.coef_quartic = 0; req_bus.coef_cubic = 0; req_bus.coef_square = 0;
      req_bus.coef_linear = 0; req_bus.coef_const = 0; req_bus.shift = 0;
      req_bus.lower_bound = 0; req_bus.upper_bound = 0;
      rsp_bus.ready = 0;
   end

   function automatic logic [31:0] pick_val(bit wide);
      case ($urandom_range(0, 7))
         0: return wide ? $urandom() : 32'h8000_0000;
         1: return wide ? 32'h7fff_ffff : $urandom();
         2, 3: return 32'($signed($urandom_range(0, 20 << NF)) - (10 << NF));
         default: return 32'($signed($urandom_range(0, 6 << NF)) - (3 << NF));
      endcase
   endfunction

   function automatic gpi_tb_pkg::gpi_item_type rand_item();
      gpi_tb_pkg::gpi_item_type it;
      bit wide;
      wide = $urandom_range(0, 9) == 0;
      it.func = $urandom_range(0, 1);
      it.qa = pick_val(wide); it.qb = pick_val(wide); it.qc = pick_val(wide);
      it.qd = pick_val(wide); it.qe = pick_val(wide);
      it.hs = $urandom_range(0, 3) == 0 ? pick_val(1) :
              32'($signed($urandom_range(0, 4 << NF)) - (2 << NF));
      it.lo = pick_val(wide);
      it.hi = pick_val(wide);
      return it;
   endfunction

   function automatic gpi_tb_pkg::gpi_item_type mk(bit f, logic [31:0] a, b, c, d, e, h,
                                                   lo, hi);
      gpi_tb_pkg::gpi_item_type it;
      it.func = f; it.qa = a; it.qb = b; it.qc = c; it.qd = d; it.qe = e;
      it.hs = h; it.lo = lo; it.hi = hi;
      return it;
   endfunction

   task automatic build_stimulus();
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MX = 32'h7fff_ffff;
      localparam logic [31:0] MN = 32'h8000_0000;
      stim.push_back(mk(0, 0, 0, 0, 0, ONE, 0, -(8 << NF), 8 << NF));
      stim.push_back(mk(0, 0, 0, 0, 0, ONE, 0, MN, MX));
      stim.push_back(mk(0, 0, 0, ONE, 0, 0, 0, -(2 << NF), 2 << NF));
      stim.push_back(mk(0, ONE, ONE, ONE, ONE, ONE, MX, 0, ONE));
      // reversed bounds
      stim.push_back(mk(0, ONE, 0, 0, 0, 0, 0, 3 << NF, -(1 << NF)));
      stim.push_back(mk(0, MX, MX, MX, MX, MX, 0, MN, MX));
      stim.push_back(mk(0, MN, MN, MN, MN, MN, 0, -(1 << NF), 1 << NF));
      stim.push_back(mk(1, ONE, 0, 0, 0, 0, ONE, -(1 << NF), 1 << NF));
      stim.push_back(mk(1, MX, MX, MX, MX, MX, MX, -(1 << NF), ONE));
      stim.push_back(mk(1, MN, MN, MN, MN, MN, MN, 0, 7 << NF));
      stim.push_back(mk(1, ONE, ONE, ONE, ONE, ONE, -(2 << NF), 0, 0));
      // bounds beyond the table
      stim.push_back(mk(1, ONE, ONE, 0, 0, 0, 1 << NF, 9 << NF, 20 << NF));
      stim.push_back(mk(0, MX, 0, 0, 0, 0, 0, 8 << NF, MX));
      stim.push_back(mk(0, 0, 0, 0, MX, 0, 0, (8 << NF) - 1, 8 << NF));
      stim.push_back(mk(0, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 32'hffff_ffff, 0, 1, 32'hffff_ffff));
      stim.push_back(mk(1, 0, 0, 0, 0, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
      for (int i = 0; i < 650; i++) stim.push_back(rand_item());
   endtask

   task automatic send_all();
      gpi_tb_pkg::gpi_item_type it;
      int gap;
      while (stim.size() > 0) begin
         it = stim.pop_front();
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_bus.valid <= 0;
            repeat (gap) @(negedge clock);
         end
         req_bus.valid <= 1;
         req_bus.func <= it.func;
         req_bus.coef_quartic <= it.qa; req_bus.coef_cubic <= it.qb;
         req_bus.coef_square <= it.qc; req_bus.coef_linear <= it.qd;
         req_bus.coef_const <= it.qe; req_bus.shift <= it.hs;
         req_bus.lower_bound <= it.lo; req_bus.upper_bound <= it.hi;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         board.note_request(it);
         @(negedge clock);
      end
      req_bus.valid <= 0;
      sending_done = 1;
   endtask

   task automatic take_results();
      int gap;
      forever begin
         if (hold_off > 0) begin
            rsp_bus.ready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_bus.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         board.check_result(rsp_bus.integral, rsp_bus.saturated);
         @(negedge clock);
      end
   endtask

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      fill_tables();
      build_stimulus();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      fork
         send_all();
         take_results();
         begin
            // long stall so the pipeline backs up into the request side
            repeat (300) @(negedge clock);
            hold_off = 200;
         end
         begin
            while (!(sending_done && board.want_val.size() == 0)) @(posedge clock);
            repeat (40) @(posedge clock);
            if (board.errors == 0 && board.want_val.size() == 0) $display("TB_OK");
            else $display("TB_ERROR");
            $finish;
         end
         begin
            wait (idle_cycles >= WD_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      join
   end
endmodule

// ===== gaussian_polynomial_integral_top.f =====
sv/gpi_pkg.sv
sv/gpi_req_if.sv
sv/gpi_rsp_if.sv
sv/gpi_lookup.sv
sv/gaussian_polynomial_integral_top.sv
test/gpi_tb_if.sv
test/tb_gaussian_polynomial_integral_top.sv
